// File: hdl/cbe_pkg.sv
// ----------------------------------------------------------------------------
// cbe_pkg - shared types and constants for the cubic-bezier easing block
// Number format, sequencer codes, register indexes and saturation helper.
// ----------------------------------------------------------------------------
package cbe_pkg;

  // signed fixed point, Q2.16
  localparam int FRAC_BITS = 16;
  localparam int VAL_W     = 18;           // t, f, y, ctrl_y
  localparam int XW        = 17;           // x and ctrl_x
  localparam int KW        = 21;           // polynomial coefficients, held exactly
  localparam int RW        = 19;           // 1 - t
  localparam int AW        = 32;           // multiplicand and accumulators
  localparam int BW        = 19;           // multiplier operand
  localparam int PW        = AW + BW;      // full product
  localparam int CFG_W     = 18;
  localparam int CFG_IDX_W = 3;
  localparam int LIMIT_W   = 5;

  localparam int ONE     = 1 << FRAC_BITS;
  localparam int HALF    = 1 << (FRAC_BITS - 1);
  localparam int EPS     = (5 * ONE + 5000) / 10000;
  localparam int VAL_MAX = (1 << (VAL_W - 1)) - 1;
  localparam int VAL_MIN = -(1 << (VAL_W - 1));

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CTRL1_X         = 3'd0,
    REG_CTRL1_Y         = 3'd1,
    REG_CTRL2_X         = 3'd2,
    REG_CTRL2_Y         = 3'd3,
    REG_ITERATION_LIMIT = 3'd4
  } reg_index_t;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_MUL  = 5'b00010,
    ST_ACC  = 5'b00100,
    ST_CHK  = 5'b01000,
    ST_FIN  = 5'b10000
  } state_t;

  // operations of the shared multiplier, in sequence order
  typedef enum logic [3:0] {
    OP_K0T = 4'd0,  // k0 * t
    OP_P1T = 4'd1,  // (k0*t + k1) * t
    OP_P2T = 4'd2,  // (.. + k2) * t
    OP_TT  = 4'd3,  // t * t
    OP_T2T = 4'd4,  // t^2 * t
    OP_RR  = 4'd5,  // (1-t)^2
    OP_T2R = 4'd6,  // t^2 * (1-t)
    OP_UBY = 4'd7,  // .. * ctrl2_y
    OP_R2T = 4'd8,  // (1-t)^2 * t
    OP_VAY = 4'd9   // .. * ctrl1_y
  } op_t;

  function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [AW-1:0] v);
    logic signed [AW-1:0] hi;
    logic signed [AW-1:0] lo;
    hi = AW'(VAL_MAX);
    lo = AW'(VAL_MIN);
    if (v > hi) begin
      sat_val = VAL_W'(VAL_MAX);
    end else if (v < lo) begin
      sat_val = VAL_W'(VAL_MIN);
    end else begin
      sat_val = v[VAL_W-1:0];
    end
  endfunction

endpackage

// File: hdl/cubic_bezier_easing.sv
// ----------------------------------------------------------------------------
// cubic_bezier_easing - cubic-bezier easing curve evaluator
// Solves t from x by damped refinement, then evaluates y(t), on one shared
// 32x19 multiplier under a small sequencer.
// ----------------------------------------------------------------------------
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------
//  cfg     | in  | cfg_write          | cfg_index, cfg_data
//  x       | in  | x_valid / x_stall  | x_in    (17 bits, unsigned)
//  y       | out | y_valid / y_stall  | y_out   (18 bits, signed)
//
//  Every multiply passes through ST_MUL and ST_ACC (product register, then round
//  and add). A refinement step is three multiplies and a check, evaluating y is
//  seven multiplies; a diagonal curve goes straight to the final state. The next
//  beat can be taken in the same cycle in which the result shows on y_out.
//  x_stall is high from acceptance until the result is loaded into y_out; a
//  finished result waits in the final state while the previous one is held
//  by y_stall. Synchronous reset restores the register defaults and drops y_valid.
//
module cubic_bezier_easing #(
  parameter int MAX_ITER = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [cbe_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [cbe_pkg::CFG_W-1:0]           cfg_data,
  input  logic                                x_valid,
  output logic                                x_stall,
  input  logic [cbe_pkg::XW-1:0]              x_in,
  output logic                                y_valid,
  input  logic                                y_stall,
  output logic signed [cbe_pkg::VAL_W-1:0]    y_out
);

  localparam int LW = $clog2(MAX_ITER + 1);
  localparam int AW = cbe_pkg::AW;
  localparam int PW = cbe_pkg::PW;

  // configuration
  logic        [cbe_pkg::XW-1:0]      ctrl1_x;
  logic signed [cbe_pkg::VAL_W-1:0]   ctrl1_y;
  logic        [cbe_pkg::XW-1:0]      ctrl2_x;
  logic signed [cbe_pkg::VAL_W-1:0]   ctrl2_y;
  logic        [cbe_pkg::LIMIT_W-1:0] iteration_limit;

  // working registers
  cbe_pkg::state_t                    state;
  cbe_pkg::op_t                       op;
  logic        [cbe_pkg::XW-1:0]      x;
  logic signed [cbe_pkg::VAL_W-1:0]   t;
  logic signed [cbe_pkg::VAL_W-1:0]   f;
  logic signed [cbe_pkg::RW-1:0]      r;
  logic signed [cbe_pkg::KW-1:0]      k0;
  logic signed [cbe_pkg::KW-1:0]      k1;
  logic signed [cbe_pkg::KW-1:0]      k2;
  logic signed [AW-1:0]               acc;
  logic signed [AW-1:0]               t2;
  logic signed [AW-1:0]               r2;
  logic signed [AW-1:0]               yacc;
  logic signed [PW-1:0]               prod;
  logic        [LW-1:0]               iter;
  logic        [LW-1:0]               lim;

  // combinational
  logic        [LW-1:0]               lim_next;
  logic signed [cbe_pkg::KW-1:0]      ax3;
  logic signed [cbe_pkg::KW-1:0]      bx3;
  logic signed [AW-1:0]               opa;
  logic signed [cbe_pkg::BW-1:0]      opb;
  logic signed [PW-1:0]               prod_rnd;
  logic signed [AW-1:0]               rnd;
  logic signed [AW-1:0]               rnd3;
  logic signed [AW-1:0]               x_ext;
  logic signed [AW-1:0]               t_step;
  logic                               diag;
  logic                               converged;
  logic                               x_acc;
  logic                               last_step;

  assign x_stall = (state != cbe_pkg::ST_IDLE);
  assign x_acc   = x_valid && !x_stall;

  assign diag = ($signed({1'b0, ctrl1_x}) == ctrl1_y) && ($signed({1'b0, ctrl2_x}) == ctrl2_y);

  always_comb begin
    if (32'(iteration_limit) > MAX_ITER) begin
      lim_next = LW'(MAX_ITER);
    end else begin
      lim_next = LW'(iteration_limit);
    end
  end

  assign ax3 = $signed(cbe_pkg::KW'(ctrl1_x)) + $signed(cbe_pkg::KW'({ctrl1_x, 1'b0}));
  assign bx3 = $signed(cbe_pkg::KW'(ctrl2_x)) + $signed(cbe_pkg::KW'({ctrl2_x, 1'b0}));

  // operand selection for the shared multiplier
  always_comb begin
    case (op)
      cbe_pkg::OP_K0T: begin opa = AW'(k0);  opb = cbe_pkg::BW'(t); end
      cbe_pkg::OP_P1T: begin opa = acc;      opb = cbe_pkg::BW'(t); end
      cbe_pkg::OP_P2T: begin opa = acc;      opb = cbe_pkg::BW'(t); end
      cbe_pkg::OP_TT:  begin opa = AW'(t);   opb = cbe_pkg::BW'(t); end
      cbe_pkg::OP_T2T: begin opa = t2;       opb = cbe_pkg::BW'(t); end
      cbe_pkg::OP_RR:  begin opa = AW'(r);   opb = r;               end
      cbe_pkg::OP_T2R: begin opa = t2;       opb = r;               end
      cbe_pkg::OP_UBY: begin opa = acc;      opb = cbe_pkg::BW'(ctrl2_y); end
      cbe_pkg::OP_R2T: begin opa = r2;       opb = cbe_pkg::BW'(t); end
      cbe_pkg::OP_VAY: begin opa = acc;      opb = cbe_pkg::BW'(ctrl1_y); end
      default:         begin opa = '0;       opb = '0;              end
    endcase
  end

  // round to nearest, ties upward: floor((p + half) / one)
  assign prod_rnd = prod + PW'(cbe_pkg::HALF);
  assign rnd      = $signed(prod_rnd[cbe_pkg::FRAC_BITS +: AW]);
  assign rnd3     = rnd + (rnd <<< 1);
  assign x_ext    = $signed(AW'(x));

  assign converged = (f <= cbe_pkg::VAL_W'(cbe_pkg::EPS)) && (f >= -cbe_pkg::VAL_W'(cbe_pkg::EPS));
  assign t_step    = AW'(t) - AW'(f >>> 1);
  assign last_step = (({1'b0, iter} + 1'b1) == {1'b0, lim});

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1_x         <= cbe_pkg::XW'(cbe_pkg::ONE * 0);
      ctrl1_y         <= '0;
      ctrl2_x         <= cbe_pkg::XW'(cbe_pkg::ONE);
      ctrl2_y         <= cbe_pkg::VAL_W'(cbe_pkg::ONE);
      iteration_limit <= cbe_pkg::LIMIT_W'(16);
    end else if (cfg_write) begin
      case (cfg_index)
        cbe_pkg::REG_CTRL1_X:         ctrl1_x <= cfg_data[cbe_pkg::XW-1:0];
        cbe_pkg::REG_CTRL1_Y:         ctrl1_y <= $signed(cfg_data);
        cbe_pkg::REG_CTRL2_X:         ctrl2_x <= cfg_data[cbe_pkg::XW-1:0];
        cbe_pkg::REG_CTRL2_Y:         ctrl2_y <= $signed(cfg_data);
        cbe_pkg::REG_ITERATION_LIMIT: iteration_limit <= cfg_data[cbe_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cbe_pkg::ST_IDLE;
      op      <= cbe_pkg::OP_K0T;
      iter    <= '0;
      lim     <= '0;
      y_valid <= 1'b0;
    end else begin
      // a new result replaces the old one in the cycle the old one leaves
      if (state == cbe_pkg::ST_FIN && (!y_valid || !y_stall)) begin
        y_valid <= 1'b1;
      end else if (y_valid && !y_stall) begin
        y_valid <= 1'b0;
      end
      case (state)
        cbe_pkg::ST_IDLE: begin
          if (x_acc) begin
            x    <= x_in;
            t    <= cbe_pkg::VAL_W'(x_in);
            iter <= '0;
            lim  <= lim_next;
            k0   <= cbe_pkg::KW'(cbe_pkg::ONE) + ax3 - bx3;
            k1   <= bx3 - (ax3 <<< 1);
            k2   <= ax3;
            yacc <= AW'(x_in);
            if (diag) begin
              state <= cbe_pkg::ST_FIN;
            end else if (lim_next == '0) begin
              op    <= cbe_pkg::OP_TT;
              state <= cbe_pkg::ST_MUL;
            end else begin
              op    <= cbe_pkg::OP_K0T;
              state <= cbe_pkg::ST_MUL;
            end
          end
        end
        cbe_pkg::ST_MUL: begin
          prod  <= opa * opb;
          state <= cbe_pkg::ST_ACC;
        end
        cbe_pkg::ST_ACC: begin
          state <= cbe_pkg::ST_MUL;
          case (op)
            cbe_pkg::OP_K0T: begin
              acc <= rnd + AW'(k1);
              op  <= cbe_pkg::OP_P1T;
            end
            cbe_pkg::OP_P1T: begin
              acc <= rnd + AW'(k2);
              op  <= cbe_pkg::OP_P2T;
            end
            cbe_pkg::OP_P2T: begin
              f     <= cbe_pkg::sat_val(rnd - x_ext);
              state <= cbe_pkg::ST_CHK;
            end
            cbe_pkg::OP_TT: begin
              t2 <= rnd;
              r  <= cbe_pkg::RW'(cbe_pkg::ONE) - cbe_pkg::RW'(t);
              op <= cbe_pkg::OP_T2T;
            end
            cbe_pkg::OP_T2T: begin
              yacc <= rnd;
              op   <= cbe_pkg::OP_RR;
            end
            cbe_pkg::OP_RR: begin
              r2 <= rnd;
              op <= cbe_pkg::OP_T2R;
            end
            cbe_pkg::OP_T2R: begin
              acc <= rnd;
              op  <= cbe_pkg::OP_UBY;
            end
            cbe_pkg::OP_UBY: begin
              yacc <= yacc + rnd3;
              op   <= cbe_pkg::OP_R2T;
            end
            cbe_pkg::OP_R2T: begin
              acc <= rnd;
              op  <= cbe_pkg::OP_VAY;
            end
            cbe_pkg::OP_VAY: begin
              yacc  <= yacc + rnd3;
              state <= cbe_pkg::ST_FIN;
            end
            default: begin
              state <= cbe_pkg::ST_IDLE;
            end
          endcase
        end
        cbe_pkg::ST_CHK: begin
          state <= cbe_pkg::ST_MUL;
          if (converged) begin
            op <= cbe_pkg::OP_TT;
          end else begin
            // t -= floor(f / 2)
            t <= cbe_pkg::sat_val(t_step);
            if (last_step) begin
              op <= cbe_pkg::OP_TT;
            end else begin
              iter <= iter + 1'b1;
              op   <= cbe_pkg::OP_K0T;
            end
          end
        end
        cbe_pkg::ST_FIN: begin
          if (!y_valid || !y_stall) begin
            y_out <= cbe_pkg::sat_val(yacc);
            state <= cbe_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= cbe_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // a new result only ever comes out of the final state
  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(y_valid) |-> $past(state == cbe_pkg::ST_FIN))
    else $error("y_valid rose outside the final state");

  // an accepted beat always starts work
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    x_acc |=> (state == cbe_pkg::ST_MUL || state == cbe_pkg::ST_FIN))
    else $error("accepted beat did not start the sequencer");

  // refinement never runs past its limit
  a_iter_bound: assert property (@(posedge clk) disable iff (rst)
    iter <= lim)
    else $error("iteration count beyond limit");

  // a waiting result is not overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (rst)
    (state == cbe_pkg::ST_FIN && y_valid && y_stall) |=>
      (state == cbe_pkg::ST_FIN && $stable(y_out)))
    else $error("result overwritten while stalled");

endmodule

// File: dv/tb_cubic_bezier_easing.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_cubic_bezier_easing - self-checking testbench for the easing evaluator
// Programs a run of curves, sends x beats with random gaps and random stalls
// on the y side, and checks every y beat against an in-bench fixed point
// solver of the same curve (damped refinement of t, then y(t)).
// ----------------------------------------------------------------------------
module tb_cubic_bezier_easing;

  localparam int MAX_STEPS       = 16;
  localparam int RESET_CYCLES    = 11;
  localparam int RANDOM_PHASES   = 12;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int DRAIN_CYCLES    = 140;
  localparam int CYCLE_LIMIT     = 2_000_000;
  localparam int FIRST_UNMAPPED  = int'(cbe_pkg::REG_ITERATION_LIMIT) + 1;

  typedef struct packed {
    logic [cbe_pkg::XW-1:0]           x;
    logic signed [cbe_pkg::VAL_W-1:0] y;
  } y_due_t;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             cfg_write = 1'b0;
  logic [cbe_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
  logic [cbe_pkg::CFG_W-1:0]        cfg_data = '0;
  logic                             x_valid = 1'b0;
  logic                             x_stall;
  logic [cbe_pkg::XW-1:0]           x_in = '0;
  logic                             y_valid;
  logic                             y_stall = 1'b0;
  logic signed [cbe_pkg::VAL_W-1:0] y_out;

  // curve as the block should hold it
  longint curve_ax = 0;
  longint curve_ay = 0;
  longint curve_bx = cbe_pkg::ONE;
  longint curve_by = cbe_pkg::ONE;
  int     curve_limit = MAX_STEPS;

  y_due_t y_due[$];
  bit     no_idle = 1'b0;
  int     stall_left = 0;
  int     mismatches = 0;
  int     items_sent = 0;
  int     results_checked = 0;
  int     curves_loaded = 0;
  int     cycles = 0;

  cubic_bezier_easing #(.MAX_ITER(MAX_STEPS)) u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .x_valid   (x_valid),
    .x_stall   (x_stall),
    .x_in      (x_in),
    .y_valid   (y_valid),
    .y_stall   (y_stall),
    .y_out     (y_out)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles, y_due.size());
      $display("Verification failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint clamp18(input longint v);
    if (v > cbe_pkg::VAL_MAX) return cbe_pkg::VAL_MAX;
    if (v < cbe_pkg::VAL_MIN) return cbe_pkg::VAL_MIN;
    return v;
  endfunction

  // rounded Q2.16 product; >>> on a signed value floors
  function automatic longint fx_mul(input longint a, input longint b);
    return (a * b + cbe_pkg::HALF) >>> cbe_pkg::FRAC_BITS;
  endfunction

  function automatic logic signed [cbe_pkg::VAL_W-1:0] ease_y(
      input logic [cbe_pkg::XW-1:0] x_val);
    longint x, k0, k1, k2, t, f, t2, t3, r, r2, y;
    int     steps;
    x = longint'(x_val);
    if (curve_ax == curve_ay && curve_bx == curve_by) return cbe_pkg::VAL_W'(clamp18(x));
    k0 = cbe_pkg::ONE + 3 * curve_ax - 3 * curve_bx;
    k1 = 3 * curve_bx - 6 * curve_ax;
    k2 = 3 * curve_ax;
    t = clamp18(x);
    steps = (curve_limit > MAX_STEPS) ? MAX_STEPS : curve_limit;
    for (int i = 0; i < steps; i++) begin
      f = fx_mul(k0, t) + k1;
      f = fx_mul(f, t) + k2;
      f = clamp18(fx_mul(f, t) - x);
      if (f <= cbe_pkg::EPS && f >= -cbe_pkg::EPS) break;
      t = clamp18(t - (f >>> 1));
    end
    t2 = fx_mul(t, t);
    t3 = fx_mul(t2, t);
    r  = cbe_pkg::ONE - t;
    r2 = fx_mul(r, r);
    y  = t3 + 3 * fx_mul(fx_mul(t2, r), curve_by) + 3 * fx_mul(fx_mul(t, r2), curve_ay);
    return cbe_pkg::VAL_W'(clamp18(y));
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic int draw_wait();
    if (no_idle) return 0;
    return $urandom_range(17, 0);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // result side: check each accepted beat, then draw the stall for the next one
  always @(posedge clk) begin : y_sink
    y_due_t want;
    int     n;
    if (rst) begin
      y_stall    <= 1'b0;
      stall_left <= 0;
    end else if (y_valid && !y_stall) begin
      results_checked++;
      if (y_due.size() == 0) begin
        report_mismatch($sformatf("unexpected y beat %0d", y_out));
      end else begin
        want = y_due.pop_front();
        if (y_out !== want.y)
          report_mismatch($sformatf("x=0x%05h y_out got %0d want %0d", want.x, y_out, want.y));
      end
      n = draw_wait();
      stall_left <= n;
      y_stall    <= (n != 0);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      y_stall    <= (stall_left > 1);
    end
  end

  task automatic send_x(input logic [cbe_pkg::XW-1:0] val);
    int gap;
    gap = draw_wait();
    if (gap != 0) begin
      x_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    x_valid <= 1'b1;
    x_in    <= val;
    do @(posedge clk); while (x_stall);
    y_due.push_back('{x: val, y: ease_y(val)});
    items_sent++;
  endtask

  // never returns without waiting on a clock edge, so a following drive never doubles up
  task automatic wait_drained();
    x_valid <= 1'b0;
    do @(posedge clk); while (y_due.size() != 0);
  endtask

  task automatic write_reg(input logic [cbe_pkg::CFG_IDX_W-1:0] idx,
                           input logic [cbe_pkg::CFG_W-1:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      cbe_pkg::REG_CTRL1_X:
        curve_ax = longint'(data[cbe_pkg::XW-1:0]);
      cbe_pkg::REG_CTRL1_Y:
        curve_ay = longint'($signed(data[cbe_pkg::VAL_W-1:0]));
      cbe_pkg::REG_CTRL2_X:
        curve_bx = longint'(data[cbe_pkg::XW-1:0]);
      cbe_pkg::REG_CTRL2_Y:
        curve_by = longint'($signed(data[cbe_pkg::VAL_W-1:0]));
      cbe_pkg::REG_ITERATION_LIMIT:
        curve_limit = int'(data[cbe_pkg::LIMIT_W-1:0]);
      default: ;
    endcase
  endtask

  // unused upper data bits carry noise; the block must mask them
  task automatic program_curve(input logic [cbe_pkg::XW-1:0] ax,
                               input logic [cbe_pkg::VAL_W-1:0] ay,
                               input logic [cbe_pkg::XW-1:0] bx,
                               input logic [cbe_pkg::VAL_W-1:0] by,
                               input logic [cbe_pkg::LIMIT_W-1:0] lim);
    wait_drained();
    write_reg(cbe_pkg::REG_CTRL1_X, {1'($urandom), ax});
    write_reg(cbe_pkg::REG_CTRL1_Y, ay);
    write_reg(cbe_pkg::REG_CTRL2_X, {1'($urandom), bx});
    write_reg(cbe_pkg::REG_CTRL2_Y, by);
    write_reg(cbe_pkg::REG_ITERATION_LIMIT,
              {(cbe_pkg::CFG_W-cbe_pkg::LIMIT_W)'($urandom), lim});
    cfg_write <= 1'b0;
    @(posedge clk);
    curves_loaded++;
  endtask

  // ---------------------------------------------------------------- tests

  // register defaults put both control points on the diagonal
  task automatic test_reset_identity();
    send_x('0);
    send_x(cbe_pkg::XW'(cbe_pkg::ONE));
    send_x('1);
    send_x(cbe_pkg::XW'(17'h0AAAA));
  endtask

  task automatic test_unmapped_index();
    wait_drained();
    for (int i = FIRST_UNMAPPED; i < (1 << cbe_pkg::CFG_IDX_W); i++)
      write_reg(cbe_pkg::CFG_IDX_W'(i), '1);
    cfg_write <= 1'b0;
    @(posedge clk);
    send_x(cbe_pkg::XW'(17'h15555));
    send_x(cbe_pkg::XW'(17'h0AAAA));
  endtask

  task automatic test_directed_curves();
    // ordinary ease curve
    program_curve(cbe_pkg::XW'(cbe_pkg::ONE / 4), cbe_pkg::VAL_W'(cbe_pkg::ONE / 10),
                  cbe_pkg::XW'(cbe_pkg::ONE / 4), cbe_pkg::VAL_W'(cbe_pkg::ONE), 5'd16);
    send_x('0);
    send_x(cbe_pkg::XW'(1));
    send_x(cbe_pkg::XW'(cbe_pkg::ONE / 2));
    send_x(cbe_pkg::XW'(cbe_pkg::ONE));
    send_x('1);
    // no refinement: y evaluated at t = x
    program_curve(cbe_pkg::XW'(cbe_pkg::ONE / 4), cbe_pkg::VAL_W'(cbe_pkg::ONE / 10),
                  cbe_pkg::XW'(cbe_pkg::ONE / 4), cbe_pkg::VAL_W'(cbe_pkg::ONE), '0);
    send_x(cbe_pkg::XW'(cbe_pkg::ONE / 4));
    send_x(cbe_pkg::XW'(3 * cbe_pkg::ONE / 4));
    // limit beyond the maximum, y at both rails
    program_curve(cbe_pkg::XW'(cbe_pkg::ONE), cbe_pkg::VAL_W'(cbe_pkg::VAL_MIN),
                  '0, cbe_pkg::VAL_W'(cbe_pkg::VAL_MAX), '1);
    send_x(cbe_pkg::XW'(cbe_pkg::ONE / 2));
    send_x(cbe_pkg::XW'(cbe_pkg::ONE));
    // control x above one, one past the maximum limit
    program_curve('1, cbe_pkg::VAL_W'(cbe_pkg::VAL_MAX), '1, cbe_pkg::VAL_W'(cbe_pkg::VAL_MIN),
                  cbe_pkg::LIMIT_W'(MAX_STEPS + 1));
    send_x('1);
    send_x(cbe_pkg::XW'(cbe_pkg::ONE));
    send_x('0);
    // diagonal away from the defaults
    program_curve(cbe_pkg::XW'(cbe_pkg::ONE / 2), cbe_pkg::VAL_W'(cbe_pkg::ONE / 2),
                  cbe_pkg::XW'(cbe_pkg::ONE / 2), cbe_pkg::VAL_W'(cbe_pkg::ONE / 2), 5'd3);
    send_x('1);
    send_x(cbe_pkg::XW'(17'h05555));
  endtask

  task automatic test_random_curves();
    logic [cbe_pkg::XW-1:0]      ax, bx, xv;
    logic [cbe_pkg::VAL_W-1:0]   ay, by;
    logic [cbe_pkg::LIMIT_W-1:0] lim;
    int                          kind;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      kind = $urandom_range(9, 0);
      ax = cbe_pkg::XW'($urandom_range(cbe_pkg::ONE, 0));
      bx = cbe_pkg::XW'($urandom_range(cbe_pkg::ONE, 0));
      ay = cbe_pkg::VAL_W'($urandom_range(3 * cbe_pkg::ONE, 0) - cbe_pkg::ONE);
      by = cbe_pkg::VAL_W'($urandom_range(3 * cbe_pkg::ONE, 0) - cbe_pkg::ONE);
      if (kind == 0) begin
        ay = cbe_pkg::VAL_W'(ax);
        by = cbe_pkg::VAL_W'(bx);
      end else if (kind == 1) begin
        ax = cbe_pkg::XW'($urandom);
        bx = cbe_pkg::XW'($urandom);
        ay = cbe_pkg::VAL_W'($urandom);
        by = cbe_pkg::VAL_W'($urandom);
      end
      lim = ($urandom_range(3, 0) == 0) ? cbe_pkg::LIMIT_W'($urandom)
                                        : cbe_pkg::LIMIT_W'($urandom_range(MAX_STEPS, 1));
      no_idle = (phase % 4 == 3);
      program_curve(ax, ay, bx, by, lim);
      repeat (ITEMS_PER_PHASE) begin
        xv = ($urandom_range(6, 0) == 0) ? cbe_pkg::XW'($urandom)
                                         : cbe_pkg::XW'($urandom_range(cbe_pkg::ONE, 0));
        send_x(xv);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    test_reset_identity();
    test_unmapped_index();
    test_directed_curves();
    test_random_curves();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (y_due.size() != 0)
      report_mismatch($sformatf("%0d y beats never arrived", y_due.size()));
    $display("Run covered %0d x beats over %0d programmed curves plus reset defaults,",
             items_sent, curves_loaded);
    $display("with %0d y beats checked and %0d mismatches.", results_checked, mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: cubic_bezier_easing.f
hdl/cbe_pkg.sv
hdl/cubic_bezier_easing.sv
dv/tb_cubic_bezier_easing.sv
